// ===== rtl/core/rrts_pkg.sv =====
// Shared constants, codes and types of the round-robin thread scheduler.
package rrts_pkg;

	localparam int MAX_THREADS = 16;
	localparam int TID_W       = $clog2(MAX_THREADS);
	localparam int CNT_W       = $clog2(MAX_THREADS + 1);
	localparam int QLEN_W      = 30;
	localparam int QCNT_W      = 32;
	localparam int OP_W        = 3;
	localparam int STATUS_W    = 3;
	localparam int IN_W        = 8;
	localparam int OUT_W       = 80;

	localparam logic [QLEN_W-1:0] QLEN_RESET = QLEN_W'(100000);

	localparam logic [OP_W-1:0] OP_TICK      = 3'd0;
	localparam logic [OP_W-1:0] OP_SPAWN     = 3'd1;
	localparam logic [OP_W-1:0] OP_TERMINATE = 3'd2;
	localparam logic [OP_W-1:0] OP_BLOCK     = 3'd3;
	localparam logic [OP_W-1:0] OP_RESUME    = 3'd4;
	localparam logic [OP_W-1:0] OP_SYNC      = 3'd5;
	localparam logic [OP_W-1:0] OP_QUERY     = 3'd6;

	localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
	localparam logic [STATUS_W-1:0] ST_INVALID_ID = 3'd1;
	localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 3'd2;
	localparam logic [STATUS_W-1:0] ST_MAIN       = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NO_READY   = 3'd4;
	localparam logic [STATUS_W-1:0] ST_MAIN_RESET = 3'd5;

	typedef enum logic [1:0] {
		MODE_READY   = 2'd0,
		MODE_RUNNING = 2'd1,
		MODE_BLOCKED = 2'd2
	} mode_t;

endpackage

// ===== rtl/core/round_robin_thread_scheduler_unit.sv =====
// Top level of the round-robin thread scheduler: sequencer, thread tables and ready ring.
//
//  Channel  | Direction | Handshake          | Payload
//  ---------+-----------+--------------------+-----------------------------------------
//  s_*      | in        | s_tvalid/s_tready  | s_tdata: operation[2:0], tid[6:3]
//  m_*      | out       | m_tvalid/m_tready  | m_tdata: status, new_id, running_id,
//           |           |                    |   total_quantums, thread_quantums, switched
//  cfg_*    | in        | cfg_we             | cfg_wdata: quantum_length
//
// One event is taken at a time. It is accepted, then decoded; starting a new quantum takes
// three steps (ring pop, per-thread count, total count), and the output load one more.
// Removing a thread from the ready ring walks the ring entries, and releasing waiters
// walks all MAX_THREADS slots. Tick, per-thread quantum and total counting go through
// the one shared incrementer.
// Reset is asynchronous and leaves thread 0 running with one quantum started. The ready
// ring itself is not cleared. A result waiting on a stalled output holds the sequencer in its
// final state; the input is only ready while the sequencer is idle.
module round_robin_thread_scheduler_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [rrts_pkg::IN_W-1:0]     s_tdata,   // operation[2:0], tid[6:3]
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [rrts_pkg::OUT_W-1:0]    m_tdata,   // status[2:0], new_id[6:3],
	                                                 // running_id[10:7], total_quantums[42:11],
	                                                 // thread_quantums[74:43], switched[75]
	input  logic                          cfg_we,
	input  logic [rrts_pkg::QLEN_W-1:0]   cfg_wdata
);
	import rrts_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DEC,
		S_POP,
		S_INCQ,
		S_INCT,
		S_REM_FIND,
		S_REM_SHIFT,
		S_REL,
		S_TERM_SW,
		S_TERM_END,
		S_FIN
	} state_t;

	state_t state_q;

	// Thread tables and scheduler state.
	logic [MAX_THREADS-1:0]  slot_used_q;
	mode_t                   mode_q [MAX_THREADS];
	logic [MAX_THREADS-1:0]  wait_q;
	logic [QCNT_W-1:0]       tqc_q [MAX_THREADS];
	logic [MAX_THREADS-1:0]  wmask_q [MAX_THREADS];
	logic [TID_W-1:0]        ring_q [MAX_THREADS];
	logic [TID_W-1:0]        head_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [TID_W-1:0]        cur_q;
	logic [QCNT_W-1:0]       total_q;
	logic [QLEN_W-1:0]       slice_q;
	logic [CNT_W-1:0]        live_q;
	logic [QLEN_W-1:0]       qlen_q;

	// Per-event working registers.
	logic [OP_W-1:0]         op_q;
	logic [TID_W-1:0]        tid_q;
	logic [STATUS_W-1:0]     status_q;
	logic [TID_W-1:0]        new_q;
	logic [QCNT_W-1:0]       tq_q;
	logic                    sw_q;
	logic                    run_q;
	logic [MAX_THREADS-1:0]  w_q;
	logic [CNT_W-1:0]        idx_q;

	// Output register.
	logic                    m_tvalid_q;
	logic [OUT_W-1:0]        m_tdata_q;

	logic [OP_W-1:0]         in_op;
	logic [TID_W-1:0]        in_tid;
	logic [QCNT_W-1:0]       alu_a;
	logic [QCNT_W-1:0]       alu_limit;
	logic [QCNT_W-1:0]       alu_sum;
	logic                    alu_reached;
	logic [TID_W-1:0]        ring_ra;
	logic [TID_W-1:0]        ring_rd;
	logic                    ring_we;
	logic [TID_W-1:0]        ring_wa;
	logic [TID_W-1:0]        ring_wd;
	logic                    push_ok;
	logic [TID_W-1:0]        push_addr;
	logic [TID_W-1:0]        free_id;
	logic                    free_found;
	logic                    spawn_ok;
	logic [TID_W-1:0]        rel_id;
	logic                    rel_hit;
	logic                    out_free;

	assign in_op   = s_tdata[OP_W-1:0];
	assign in_tid  = s_tdata[OP_W+TID_W-1:OP_W];
	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign out_free = !m_tvalid_q || m_tready;

	assign push_ok   = (cnt_q < CNT_W'(MAX_THREADS));
	assign push_addr = head_q + cnt_q[TID_W-1:0];
	assign rel_id    = idx_q[TID_W-1:0];
	assign rel_hit   = w_q[rel_id] && slot_used_q[rel_id];

	// Lowest free slot above main.
	always_comb begin
		free_id    = '0;
		free_found = 1'b0;
		for (int i = MAX_THREADS - 1; i >= 1; i--) begin
			if (!slot_used_q[i]) begin
				free_id    = TID_W'(i);
				free_found = 1'b1;
			end
		end
	end
	assign spawn_ok = free_found && (live_q < CNT_W'(MAX_THREADS));

	// The shared incrementer serves the tick counter, the thread count and the total.
	always_comb begin
		alu_limit = {{(QCNT_W-QLEN_W){1'b0}}, qlen_q};
		if (qlen_q == '0) begin
			alu_limit = QCNT_W'(1);
		end
		case (state_q)
			S_INCQ:  alu_a = tqc_q[cur_q];
			S_INCT:  alu_a = total_q;
			default: alu_a = {{(QCNT_W-QLEN_W){1'b0}}, slice_q};
		endcase
	end

	rrts_alu u_alu (
		.operand (alu_a),
		.limit   (alu_limit),
		.sum     (alu_sum),
		.reached (alu_reached)
	);

	// Ready ring: one read and one write address per cycle.
	always_comb begin
		case (state_q)
			S_REM_FIND:  ring_ra = head_q + idx_q[TID_W-1:0];
			S_REM_SHIFT: ring_ra = head_q + idx_q[TID_W-1:0] + TID_W'(1);
			default:     ring_ra = head_q;
		endcase
	end
	assign ring_rd = ring_q[ring_ra];

	always_comb begin
		ring_we = 1'b0;
		ring_wa = push_addr;
		ring_wd = tid_q;
		case (state_q)
			S_DEC: begin
				case (op_q)
					OP_TICK: begin
						ring_we = alu_reached && push_ok;
						ring_wd = cur_q;
					end
					OP_SPAWN: begin
						ring_we = spawn_ok && push_ok;
						ring_wd = free_id;
					end
					OP_RESUME: begin
						ring_we = slot_used_q[tid_q] && (mode_q[tid_q] == MODE_BLOCKED)
							&& !wait_q[tid_q] && push_ok;
					end
					default: ring_we = 1'b0;
				endcase
			end
			S_REL: begin
				ring_we = rel_hit && (mode_q[rel_id] == MODE_BLOCKED) && push_ok;
				ring_wd = rel_id;
			end
			S_REM_SHIFT: begin
				ring_we = ((idx_q + CNT_W'(1)) < cnt_q);
				ring_wa = head_q + idx_q[TID_W-1:0];
				ring_wd = ring_rd;
			end
			default: ring_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ring_we) begin
			ring_q[ring_wa] <= ring_wd;
		end
	end

	// Sequencer with thread tables and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			slot_used_q <= MAX_THREADS'(1);
			wait_q      <= '0;
			for (int i = 0; i < MAX_THREADS; i++) begin
				mode_q[i]  <= MODE_READY;
				tqc_q[i]   <= '0;
				wmask_q[i] <= '0;
			end
			mode_q[0]   <= MODE_RUNNING;
			tqc_q[0]    <= QCNT_W'(1);
			head_q      <= '0;
			cnt_q       <= '0;
			cur_q       <= '0;
			total_q     <= QCNT_W'(1);
			slice_q     <= '0;
			live_q      <= CNT_W'(1);
			qlen_q      <= QLEN_RESET;
			op_q        <= '0;
			tid_q       <= '0;
			status_q    <= ST_OK;
			new_q       <= '0;
			tq_q        <= '0;
			sw_q        <= 1'b0;
			run_q       <= 1'b0;
			w_q         <= '0;
			idx_q       <= '0;
			m_tvalid_q  <= 1'b0;
			m_tdata_q   <= '0;
		end else begin
			if (cfg_we) begin
				qlen_q <= cfg_wdata;
			end
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (ring_we && state_q != S_REM_SHIFT) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						op_q     <= in_op;
						tid_q    <= in_tid;
						status_q <= ST_OK;
						new_q    <= '0;
						tq_q     <= '0;
						sw_q     <= 1'b0;
						run_q    <= 1'b0;
						idx_q    <= '0;
						state_q  <= S_DEC;
					end
				end
				S_DEC: begin
					state_q <= S_FIN;
					case (op_q)
						OP_TICK: begin
							if (alu_reached) begin
								mode_q[cur_q] <= MODE_READY;
								state_q       <= S_POP;
							end else begin
								slice_q <= alu_sum[QLEN_W-1:0];
							end
						end
						OP_SPAWN: begin
							if (!spawn_ok) begin
								status_q <= ST_TABLE_FULL;
							end else begin
								slot_used_q[free_id] <= 1'b1;
								mode_q[free_id]      <= MODE_READY;
								wait_q[free_id]      <= 1'b0;
								tqc_q[free_id]       <= '0;
								wmask_q[free_id]     <= '0;
								live_q               <= live_q + CNT_W'(1);
								new_q                <= free_id;
							end
						end
						OP_TERMINATE: begin
							if (!slot_used_q[tid_q]) begin
								status_q <= ST_INVALID_ID;
							end else if (tid_q == '0) begin
								// Terminating main returns every table to its reset state.
								slot_used_q <= MAX_THREADS'(1);
								wait_q      <= '0;
								for (int i = 0; i < MAX_THREADS; i++) begin
									mode_q[i]  <= MODE_READY;
									tqc_q[i]   <= '0;
									wmask_q[i] <= '0;
								end
								mode_q[0] <= MODE_RUNNING;
								tqc_q[0]  <= QCNT_W'(1);
								head_q    <= '0;
								cnt_q     <= '0;
								cur_q     <= '0;
								total_q   <= QCNT_W'(1);
								slice_q   <= '0;
								live_q    <= CNT_W'(1);
								status_q  <= ST_MAIN_RESET;
							end else if ((tid_q == cur_q) && (cnt_q == '0)
								&& (wmask_q[tid_q] == '0)) begin
								status_q <= ST_NO_READY;
							end else begin
								run_q <= (tid_q == cur_q);
								w_q   <= wmask_q[tid_q];
								if ((mode_q[tid_q] == MODE_READY) && (tid_q != cur_q)) begin
									state_q <= S_REM_FIND;
								end else begin
									state_q <= S_REL;
								end
							end
						end
						OP_BLOCK: begin
							if (!slot_used_q[tid_q]) begin
								status_q <= ST_INVALID_ID;
							end else if (tid_q == '0) begin
								status_q <= ST_MAIN;
							end else if (mode_q[tid_q] == MODE_BLOCKED) begin
								status_q <= ST_OK;
							end else if (tid_q == cur_q) begin
								if (cnt_q == '0) begin
									status_q <= ST_NO_READY;
								end else begin
									mode_q[tid_q] <= MODE_BLOCKED;
									state_q       <= S_POP;
								end
							end else begin
								mode_q[tid_q] <= MODE_BLOCKED;
								state_q       <= S_REM_FIND;
							end
						end
						OP_RESUME: begin
							if (!slot_used_q[tid_q]) begin
								status_q <= ST_INVALID_ID;
							end else if ((mode_q[tid_q] == MODE_BLOCKED) && !wait_q[tid_q]) begin
								mode_q[tid_q] <= MODE_READY;
							end
						end
						OP_SYNC: begin
							if (!slot_used_q[tid_q]) begin
								status_q <= ST_INVALID_ID;
							end else if (tid_q == '0) begin
								status_q <= ST_MAIN;
							end else if (tid_q == cur_q) begin
								status_q <= ST_INVALID_ID;
							end else if (cnt_q == '0) begin
								status_q <= ST_NO_READY;
							end else begin
								wmask_q[tid_q][cur_q] <= 1'b1;
								wait_q[cur_q]         <= 1'b1;
								mode_q[cur_q]         <= MODE_BLOCKED;
								state_q               <= S_POP;
							end
						end
						OP_QUERY: begin
							if (!slot_used_q[tid_q]) begin
								status_q <= ST_INVALID_ID;
							end else begin
								tq_q <= tqc_q[tid_q];
							end
						end
						default: status_q <= ST_OK;
					endcase
				end
				S_REM_FIND: begin
					if (idx_q >= cnt_q) begin
						idx_q   <= '0;
						state_q <= (op_q == OP_TERMINATE) ? S_REL : S_FIN;
					end else if (ring_rd == tid_q) begin
						state_q <= S_REM_SHIFT;
					end else begin
						idx_q <= idx_q + CNT_W'(1);
					end
				end
				S_REM_SHIFT: begin
					// Close the gap one entry a cycle, then drop the tail.
					if ((idx_q + CNT_W'(1)) < cnt_q) begin
						idx_q <= idx_q + CNT_W'(1);
					end else begin
						cnt_q   <= cnt_q - CNT_W'(1);
						idx_q   <= '0;
						state_q <= (op_q == OP_TERMINATE) ? S_REL : S_FIN;
					end
				end
				S_REL: begin
					// Release waiters of the terminating thread in ascending id.
					if (rel_hit) begin
						wait_q[rel_id] <= 1'b0;
						if (mode_q[rel_id] == MODE_BLOCKED) begin
							mode_q[rel_id] <= MODE_READY;
						end
					end
					if (idx_q == CNT_W'(MAX_THREADS - 1)) begin
						state_q <= S_TERM_SW;
					end else begin
						idx_q <= idx_q + CNT_W'(1);
					end
				end
				S_TERM_SW: begin
					for (int i = 0; i < MAX_THREADS; i++) begin
						wmask_q[i][tid_q] <= 1'b0;
					end
					state_q <= (run_q && (cnt_q != '0)) ? S_POP : S_TERM_END;
				end
				S_POP: begin
					cur_q           <= ring_rd;
					mode_q[ring_rd] <= MODE_RUNNING;
					head_q          <= head_q + TID_W'(1);
					cnt_q           <= cnt_q - CNT_W'(1);
					state_q         <= S_INCQ;
				end
				S_INCQ: begin
					tqc_q[cur_q] <= alu_sum;
					state_q      <= S_INCT;
				end
				S_INCT: begin
					total_q <= alu_sum;
					slice_q <= '0;
					sw_q    <= 1'b1;
					state_q <= (op_q == OP_TERMINATE) ? S_TERM_END : S_FIN;
				end
				S_TERM_END: begin
					slot_used_q[tid_q] <= 1'b0;
					mode_q[tid_q]      <= MODE_READY;
					wait_q[tid_q]      <= 1'b0;
					tqc_q[tid_q]       <= '0;
					wmask_q[tid_q]     <= '0;
					live_q             <= live_q - CNT_W'(1);
					state_q            <= S_FIN;
				end
				S_FIN: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {4'b0, sw_q, tq_q, total_q, cur_q, new_q, status_q};
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Main never leaves its slot.
	a_main_used: assert property (@(posedge clk) disable iff (!arst_n)
		slot_used_q[0])
		else $error("main thread slot freed");

	// While the sequencer is idle, the running thread owns a slot and is marked running.
	a_cur_running: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (slot_used_q[cur_q] && (mode_q[cur_q] == MODE_RUNNING)))
		else $error("running thread not in a live running slot");

	// While the sequencer is idle, the ring holds fewer entries than threads alive.
	a_ring_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (cnt_q < live_q))
		else $error("ready ring larger than live threads");

	// A result is only presented from the final state.
	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> ($past(state_q) == S_FIN))
		else $error("result presented outside final state");

endmodule

// ===== rtl/core/rrts_alu.sv =====
// Shared 32-bit incrementer with limit compare, used for ticks and quantum counters.
module rrts_alu (
	input  logic [rrts_pkg::QCNT_W-1:0] operand,
	input  logic [rrts_pkg::QCNT_W-1:0] limit,
	output logic [rrts_pkg::QCNT_W-1:0] sum,
	output logic                        reached
);
	import rrts_pkg::*;

	// The sum wraps, as the quantum counters do.
	assign sum     = operand + QCNT_W'(1);
	assign reached = (sum >= limit);

endmodule
